### sv/ecc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecc_pkg
// Constants, types and calendar tables for the epoch calendar converter.
// ----------------------------------------------------------------------------
package ecc_pkg;

	typedef logic [15:0] days_t;	// day count since 2000-01-01, below 36525
	typedef logic [16:0] sod_t;	// second of day, below 86400

	localparam logic OP_CAL_TO_POSIX = 1'b0;
	localparam logic OP_POSIX_TO_CAL = 1'b1;

	localparam logic [31:0] EPOCH_2000      = 32'd946684800;
	localparam logic [31:0] EPOCH_2100_LAST = 32'd4102444799;

	localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
	localparam logic [16:0] SECS_PER_MIN  = 17'd60;
	localparam logic [15:0] DAYS_PER_YEAR = 16'd365;
	localparam logic [15:0] DAYS_PER_CYC  = 16'd1461;
	localparam logic [10:0] DAYS_YR1      = 11'd366;
	localparam logic [10:0] DAYS_YR2      = 11'd731;
	localparam logic [10:0] DAYS_YR3      = 11'd1096;

	// Rounded-up reciprocals: floor(x * R >> K) == floor(x / d) over the operand range.
	// (seconds >> 7) / 675, 25-bit operand
	localparam logic [25:0] DAY_RECIP  = 26'd50903317;
	localparam int          DAY_SHIFT  = 35;
	// days / 1461, 16-bit operand
	localparam logic [16:0] CYC_RECIP  = 17'd91868;
	localparam int          CYC_SHIFT  = 27;
	// second of day / 3600, 17-bit operand
	localparam logic [17:0] HOUR_RECIP = 18'd149131;
	localparam int          HOUR_SHIFT = 29;
	// second of hour / 60, 12-bit operand
	localparam logic [12:0] MIN_RECIP  = 13'd4370;
	localparam int          MIN_SHIFT  = 18;

	// Days in the year before the first of the month; 0 for a bad month.
	function automatic logic [8:0] prior_days(input logic [3:0] month, input logic leap);
		logic [8:0] d;
		case (month)
			4'd1: d = 9'd0;
			4'd2: d = 9'd31;
			4'd3: d = 9'd59;
			4'd4: d = 9'd90;
			4'd5: d = 9'd120;
			4'd6: d = 9'd151;
			4'd7: d = 9'd181;
			4'd8: d = 9'd212;
			4'd9: d = 9'd243;
			4'd10: d = 9'd273;
			4'd11: d = 9'd304;
			4'd12: d = 9'd334;
			default: d = 9'd0;
		endcase
		if (month >= 4'd3 && month <= 4'd12)
			d = d + 9'(leap);
		return d;
	endfunction

	// Length of the month in days; 0 for a bad month.
	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		logic [4:0] d;
		case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			4'd2: d = 5'd28 + 5'(leap);
			default: d = 5'd0;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

### sv/epoch_calendar_converter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_calendar_converter_unit
// Converts UTC calendar time in 2000..2099 to and from 32-bit POSIX seconds.
// ----------------------------------------------------------------------------
// One request is taken per clock while res_ready stays high. The path is
// a five-register pipeline (input register, three work stages, result
// register); each stage holds at most one constant-reciprocal multiply,
// which sets the depth. Every stage has its own valid bit, so bubbles
// close up and new requests keep entering while a finished result waits
// on res_ready, until every stage is full.
// Invalid input gives a result with ok low and every other field zero.
module epoch_calendar_converter_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic        op,
	input  wire logic [7:0]  year_in,
	input  wire logic [3:0]  month_in,
	input  wire logic [4:0]  day_in,
	input  wire logic [4:0]  hour_in,
	input  wire logic [5:0]  minute_in,
	input  wire logic [5:0]  second_in,
	input  wire logic [31:0] posix_in,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic             ok,
	output logic [31:0]      posix_out,
	output logic [6:0]       year_out,
	output logic [3:0]       month_out,
	output logic [4:0]       day_out,
	output logic [4:0]       hour_out,
	output logic [5:0]       minute_out,
	output logic [5:0]       second_out
);

	// ---------------- flow control ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	assign en_s5     = !v_s5 || res_ready;
	assign en_s4     = !v_s4 || en_s5;
	assign en_s3     = !v_s3 || en_s4;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign req_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= req_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// ---------------- stage 1: input register ----------------
	logic        op_s1;
	logic [7:0]  year_s1;
	logic [3:0]  month_s1;
	logic [4:0]  day_s1;
	logic [4:0]  hour_s1;
	logic [5:0]  minute_s1;
	logic [5:0]  second_s1;
	logic [31:0] posix_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			op_s1     <= op;
			year_s1   <= year_in;
			month_s1  <= month_in;
			day_s1    <= day_in;
			hour_s1   <= hour_in;
			minute_s1 <= minute_in;
			second_s1 <= second_in;
			posix_s1  <= posix_in;
		end
	end

	// ---------------- stage A: checks, day count, day split ----------------
	logic              leap_a;
	logic              cal_ok_a;
	logic              rng_ok_a;
	ecc_pkg::days_t    dcnt_a;
	ecc_pkg::sod_t     tod_a;
	logic [31:0]       rel_a;
	logic [50:0]       xprod_a;

	always_comb begin
		leap_a   = (year_s1[1:0] == 2'b00);
		cal_ok_a = (year_s1 <= 8'd99) && (month_s1 >= 4'd1) && (month_s1 <= 4'd12) &&
			(day_s1 != 5'd0) && (day_s1 <= ecc_pkg::month_len(month_s1, leap_a)) &&
			(hour_s1 <= 5'd23) && (minute_s1 <= 6'd59) && (second_s1 <= 6'd59);
		// years * 365 + leap days already passed + days before month + day - 1
		dcnt_a = 16'(year_s1[6:0]) * ecc_pkg::DAYS_PER_YEAR
			+ 16'((8'(year_s1[6:0]) + 8'd3) >> 2)
			+ 16'(ecc_pkg::prior_days(month_s1, leap_a))
			+ 16'(day_s1) - 16'd1;
		tod_a = 17'(hour_s1) * ecc_pkg::SECS_PER_HOUR
			+ 17'(minute_s1) * ecc_pkg::SECS_PER_MIN + 17'(second_s1);
		rng_ok_a = (posix_s1 >= ecc_pkg::EPOCH_2000) && (posix_s1 <= ecc_pkg::EPOCH_2100_LAST);
		rel_a    = posix_s1 - ecc_pkg::EPOCH_2000;
		// 86400 = 128 * 675: drop the low 7 bits, then divide by 675
		xprod_a  = 51'(rel_a[31:7]) * 51'(ecc_pkg::DAY_RECIP);
	end

	logic           op_s2, ok_s2;
	ecc_pkg::days_t dcnt_s2;
	ecc_pkg::sod_t  tod_s2;
	logic [24:0]    relx_s2;
	logic [6:0]     rello_s2;
	ecc_pkg::days_t days_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			op_s2    <= op_s1;
			ok_s2    <= (op_s1 == ecc_pkg::OP_POSIX_TO_CAL) ? rng_ok_a : cal_ok_a;
			dcnt_s2  <= dcnt_a;
			tod_s2   <= tod_a;
			relx_s2  <= rel_a[31:7];
			rello_s2 <= rel_a[6:0];
			days_s2  <= xprod_a[ecc_pkg::DAY_SHIFT +: 16];
		end
	end

	// ---------------- stage B: seconds sum, cycle index ----------------
	logic [32:0] cprod_b;
	logic [24:0] pd_b;
	logic [31:0] posix_b;

	always_comb begin
		cprod_b = 33'(days_s2) * 33'(ecc_pkg::CYC_RECIP);
		pd_b    = 25'(days_s2) * 25'd675;
		posix_b = ecc_pkg::EPOCH_2000 + 32'(dcnt_s2) * 32'(ecc_pkg::SECS_PER_DAY)
			+ 32'(tod_s2);
	end

	logic           op_s3, ok_s3;
	ecc_pkg::days_t days_s3;
	logic [4:0]     cidx_s3;
	logic [24:0]    pd_s3;
	logic [24:0]    relx_s3;
	logic [6:0]     rello_s3;
	logic [31:0]    posix_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			op_s3    <= op_s2;
			ok_s3    <= ok_s2;
			days_s3  <= days_s2;
			cidx_s3  <= cprod_b[ecc_pkg::CYC_SHIFT +: 5];
			pd_s3    <= pd_b;
			relx_s3  <= relx_s2;
			rello_s3 <= rello_s2;
			posix_s3 <= posix_b;
		end
	end

	// ---------------- stage C: second of day, hour, year ----------------
	logic [9:0]     sub_c;
	ecc_pkg::sod_t  sod_c;
	logic [34:0]    hprod_c;
	ecc_pkg::days_t cyc_days_c;
	logic [10:0]    doc_c;
	logic [1:0]     yi_c;
	logic [8:0]     doy_c;

	always_comb begin
		sub_c      = 10'(relx_s3 - pd_s3);
		sod_c      = {sub_c, rello_s3};
		hprod_c    = 35'(sod_c) * 35'(ecc_pkg::HOUR_RECIP);
		cyc_days_c = 16'(cidx_s3) * ecc_pkg::DAYS_PER_CYC;
		doc_c      = 11'(days_s3 - cyc_days_c);
		if (doc_c >= ecc_pkg::DAYS_YR3) begin
			yi_c  = 2'd3;
			doy_c = 9'(doc_c - ecc_pkg::DAYS_YR3);
		end else if (doc_c >= ecc_pkg::DAYS_YR2) begin
			yi_c  = 2'd2;
			doy_c = 9'(doc_c - ecc_pkg::DAYS_YR2);
		end else if (doc_c >= ecc_pkg::DAYS_YR1) begin
			yi_c  = 2'd1;
			doy_c = 9'(doc_c - ecc_pkg::DAYS_YR1);
		end else begin
			yi_c  = 2'd0;
			doy_c = 9'(doc_c);
		end
	end

	logic          op_s4, ok_s4;
	logic [31:0]   posix_s4;
	logic [6:0]    yr_s4;
	logic [8:0]    doy_s4;
	logic          leap_s4;
	ecc_pkg::sod_t sod_s4;
	logic [4:0]    hour_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			op_s4    <= op_s3;
			ok_s4    <= ok_s3;
			posix_s4 <= posix_s3;
			yr_s4    <= {cidx_s3, yi_c};
			doy_s4   <= doy_c;
			leap_s4  <= (yi_c == 2'd0);
			sod_s4   <= sod_c;
			hour_s4  <= hprod_c[ecc_pkg::HOUR_SHIFT +: 5];
		end
	end

	// ---------------- stage D: month, day, minute, second ----------------
	logic [3:0]  month_d;
	logic [4:0]  day_d;
	logic [11:0] soh_d;
	logic [24:0] mprod_d;
	logic [5:0]  minute_d;
	logic [5:0]  second_d;

	always_comb begin
		// thresholds rise with the month, so the last hit is the month
		month_d = 4'd1;
		for (int m = 2; m <= 12; m++) begin
			if (doy_s4 >= ecc_pkg::prior_days(4'(m), leap_s4))
				month_d = 4'(m);
		end
		day_d    = 5'(doy_s4 - ecc_pkg::prior_days(month_d, leap_s4) + 9'd1);
		soh_d    = 12'(sod_s4 - 17'(hour_s4) * ecc_pkg::SECS_PER_HOUR);
		mprod_d  = 25'(soh_d) * 25'(ecc_pkg::MIN_RECIP);
		minute_d = mprod_d[ecc_pkg::MIN_SHIFT +: 6];
		second_d = 6'(soh_d - 12'(minute_d) * 12'd60);
	end

	// ---------------- stage 5: result register ----------------
	logic        ok_s5;
	logic [31:0] posix_s5;
	logic [6:0]  year_s5;
	logic [3:0]  month_s5;
	logic [4:0]  day_s5;
	logic [4:0]  hour_s5;
	logic [5:0]  minute_s5;
	logic [5:0]  second_s5;
	logic        cal_sel_d;
	logic        posix_sel_d;

	assign posix_sel_d = ok_s4 && (op_s4 == ecc_pkg::OP_CAL_TO_POSIX);
	assign cal_sel_d   = ok_s4 && (op_s4 == ecc_pkg::OP_POSIX_TO_CAL);

	always_ff @(posedge clk) begin
		if (en_s5) begin
			ok_s5     <= ok_s4;
			posix_s5  <= posix_sel_d ? posix_s4 : 32'd0;
			year_s5   <= cal_sel_d ? yr_s4 : 7'd0;
			month_s5  <= cal_sel_d ? month_d : 4'd0;
			day_s5    <= cal_sel_d ? day_d : 5'd0;
			hour_s5   <= cal_sel_d ? hour_s4 : 5'd0;
			minute_s5 <= cal_sel_d ? minute_d : 6'd0;
			second_s5 <= cal_sel_d ? second_d : 6'd0;
		end
	end

	assign res_valid  = v_s5;
	assign ok         = ok_s5;
	assign posix_out  = posix_s5;
	assign year_out   = year_s5;
	assign month_out  = month_s5;
	assign day_out    = day_s5;
	assign hour_out   = hour_s5;
	assign minute_out = minute_s5;
	assign second_out = second_s5;

`ifndef NO_ASSERTIONS
	// rejected requests carry an all-zero result
	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !ok |-> posix_out == 32'd0 && year_out == 7'd0 && month_out == 4'd0 &&
		day_out == 5'd0 && hour_out == 5'd0 && minute_out == 6'd0 && second_out == 6'd0)
		else $error("failed result has nonzero fields");

	// calendar results stay in their ranges
	a_cal_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && ok && posix_out == 32'd0 |-> month_out >= 4'd1 && month_out <= 4'd12 &&
		day_out >= 5'd1 && year_out <= 7'd99 && hour_out <= 5'd23 &&
		minute_out <= 6'd59 && second_out <= 6'd59)
		else $error("calendar field out of range");

	a_day_fits: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && ok && posix_out == 32'd0 |->
		day_out <= ecc_pkg::month_len(month_out, year_out[1:0] == 2'b00))
		else $error("day beyond end of month");

	// an item held in the last work stage is never dropped while stalled
	a_hold_s4: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !en_s5 |=> v_s4)
		else $error("stalled item lost in stage 4");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> v_s1)
		else $error("accepted request not captured");
`endif

endmodule
`default_nettype wire
